/* rtl/point_to_polygon_edge_distance_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the polygon edge distance block
// Implication checks on the block clock, with reset disabling the check.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_POLYGON_EDGE_DISTANCE_MACROS_SVH
`define POINT_TO_POLYGON_EDGE_DISTANCE_MACROS_SVH

`ifndef SYNTH
`define PPD_ASSERT_IMP(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define PPD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define PPD_ASSERT_IMP(name, clk_s, rstn_s, ante, cons)
`define PPD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons)
`endif

`endif

/* rtl/ppd_pkg.sv */
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and fixed constants of the polygon edge distance block.
// ----------------------------------------------------------------------------
package ppd_pkg;

	localparam int BEST_W = 64;
	localparam int DIST_W = 32;

	localparam logic CMD_QUERY  = 1'b0;
	localparam logic CMD_VERTEX = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_ACC,
		ST_DECIDE,
		ST_DIV,
		ST_MIN,
		ST_SQRT
	} state_t;

	typedef enum logic [3:0] {
		OP_LEN0,
		OP_LEN1,
		OP_DT0,
		OP_DT1,
		OP_AP0,
		OP_AP1,
		OP_BP0,
		OP_BP1,
		OP_CR0,
		OP_CR1,
		OP_SQ_HH,
		OP_SQ_HL,
		OP_SQ_LL
	} op_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_MID,
		SH_HIGH
	} shift_t;

	typedef struct packed {
		logic   clr;
		logic   sub;
		shift_t shift;
	} mac_ctl_t;

endpackage

/* rtl/ppd_if.sv */
// ----------------------------------------------------------------------------
// ppd_if
// Valid/ready channels for vertex requests and distance results.
// ----------------------------------------------------------------------------
interface ppd_in_if #(
	parameter int COORD_BITS = 21
) ();
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic                         is_last;

	modport source (output valid, command, coord_x, coord_y, is_last, input ready);
	modport sink (input valid, command, coord_x, coord_y, is_last, output ready);
endinterface

interface ppd_out_if
	import ppd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;

	modport source (output valid, distance, input ready);
	modport sink (input valid, distance, output ready);
endinterface

/* rtl/ppd_mul.sv */
// ----------------------------------------------------------------------------
// ppd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ppd_mul #(
	parameter int W = 23
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

/* rtl/ppd_div.sv */
// ----------------------------------------------------------------------------
// ppd_div
// Restoring divider, one quotient bit a cycle: floor(num * 4^FRAC_BITS / den)
// saturated to 64 bits.
// ----------------------------------------------------------------------------
module ppd_div
	import ppd_pkg::*;
#(
	parameter int COORD_BITS = 21,
	parameter int FRAC_BITS  = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [4*COORD_BITS+1:0]         num,
	input  logic [2*COORD_BITS:0]           den,
	output logic                            busy,
	output logic [BEST_W-1:0]               quot
);

	localparam int LEN_W = 2 * COORD_BITS + 1;
	localparam int NUM_W = 4 * COORD_BITS + 2;
	localparam int QB    = LEN_W + 2 * FRAC_BITS;
	localparam int WB    = QB + BEST_W;
	localparam int CNT_W = $clog2(QB + 1);

	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] den_q;
	logic [QB-1:0]    bits_q;
	logic [QB-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   diff;
	logic             fits;
	logic [WB-1:0]    quo_wide;

	assign trial    = {rem_q, bits_q[QB-1]};
	assign fits     = trial >= {1'b0, den_q};
	assign diff     = trial - {1'b0, den_q};
	assign quo_wide = WB'(quo_q);
	assign quot     = (|quo_wide[WB-1:BEST_W]) ? '1 : quo_wide[BEST_W-1:0];
	assign busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QB);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[NUM_W-1:LEN_W];
			bits_q <= {num[LEN_W-1:0], {(2*FRAC_BITS){1'b0}}};
			den_q  <= den;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
			bits_q <= bits_q << 1;
			quo_q  <= {quo_q[QB-2:0], fits};
		end
	end

endmodule

/* rtl/ppd_sqrt.sv */
// ----------------------------------------------------------------------------
// ppd_sqrt
// Digit-by-digit integer square root, one result bit a cycle.
// ----------------------------------------------------------------------------
module ppd_sqrt
	import ppd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [BEST_W-1:0] radicand,
	output logic              busy,
	output logic [DIST_W-1:0] root
);

	localparam int CNT_W = $clog2(DIST_W + 1);

	logic [BEST_W-1:0] rad_q;
	logic [DIST_W:0]   rem_q;
	logic [DIST_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [DIST_W+1:0] rem_sh;
	logic [DIST_W+1:0] trial;
	logic [DIST_W+1:0] diff;
	logic              fits;

	assign rem_sh = {rem_q[DIST_W-1:0], rad_q[BEST_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;
	assign diff   = rem_sh - trial;
	assign busy   = busy_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIST_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? diff[DIST_W:0] : rem_sh[DIST_W:0];
			root_q <= {root_q[DIST_W-2:0], fits};
		end
	end

endmodule

/* rtl/point_to_polygon_edge_distance.sv */
// ----------------------------------------------------------------------------
// point_to_polygon_edge_distance
// Distance from a query point to the boundary of a closed polygon.
// ----------------------------------------------------------------------------
// req carries one request a cycle at most: command 0 sets the query point and
// drops any partial polygon; command 1 delivers the next vertex, and is_last
// closes the polygon back to its first vertex. rsp carries one Q22.10 (by
// default) distance per closed polygon: floor of the true distance.
// A query request or a first vertex only updates registers. Each segment is
// worked on a shared multiplier under a small sequencer, which also runs the
// one-bit-a-cycle divider when the nearest point lies inside the segment
// rather than at a segment end. The last vertex runs two segments, then the
// square root. req.ready is high only while the sequencer is idle.
// The result sits in an output register; the next request is taken while it
// waits, and a following result waits in the root stage until rsp takes it.
// Reset clears the query point to the origin, empties the polygon and sets
// the running minimum to all ones.
// ----------------------------------------------------------------------------
`include "point_to_polygon_edge_distance_macros.svh"

module point_to_polygon_edge_distance
	import ppd_pkg::*;
#(
	parameter int COORD_BITS = 21,
	parameter int FRAC_BITS  = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	ppd_in_if.sink    req,
	ppd_out_if.source rsp
);

	localparam int DW    = COORD_BITS + 1;
	localparam int MW    = COORD_BITS + 2;
	localparam int PW    = 2 * MW;
	localparam int H     = COORD_BITS + 1;
	localparam int CW    = 2 * COORD_BITS + 1;
	localparam int LEN_W = 2 * COORD_BITS + 1;
	localparam int DT_W  = 2 * COORD_BITS + 2;
	localparam int NUM_W = 4 * COORD_BITS + 2;
	localparam int ACC_W = 4 * COORD_BITS + 3;
	localparam int QB    = LEN_W + 2 * FRAC_BITS;
	localparam int WB    = QB + BEST_W;

	state_t state_q, state_d;
	op_t    op_q, op_d;

	logic signed [COORD_BITS-1:0] query_x_q, query_y_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
	logic                         have_q, close_q, emit_q;
	logic [BEST_W-1:0]            best_q, cand_q;
	logic                         out_valid_q;
	logic [DIST_W-1:0]            dist_q;

	logic signed [DW-1:0]    abx_q, aby_q, apx_q, apy_q, bpx_q, bpy_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [LEN_W-1:0]        len_q;
	logic signed [DT_W-1:0]  dt_q;
	logic [CW-1:0]           c_q;

	logic                    in_fire;
	mac_ctl_t                ctl;
	logic signed [MW-1:0]    mul_a, mul_b;
	logic signed [PW-1:0]    mul_p;
	logic signed [ACC_W-1:0] prod_ext, term, base, acc_next, acc_mag;
	logic [QB-1:0]           sq_scaled;
	logic [WB-1:0]           sq_wide;
	logic [BEST_W-1:0]       cand_end;
	logic [BEST_W-1:0]       best_min;
	logic                    dt_le0, dt_ge_len;
	logic                    div_start, div_busy;
	logic [BEST_W-1:0]       div_quot;
	logic                    sqrt_start, sqrt_busy;
	logic [DIST_W-1:0]       sqrt_root;
	logic                    out_load;

	assign in_fire      = req.valid && req.ready;
	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.distance = dist_q;

	// Operand select and accumulate control per step
	always_comb begin
		ctl   = '{clr: 1'b1, sub: 1'b0, shift: SH_NONE};
		mul_a = MW'(abx_q);
		mul_b = MW'(abx_q);
		unique case (op_q)
			OP_LEN0: begin
				mul_a = MW'(abx_q);
				mul_b = MW'(abx_q);
			end
			OP_LEN1: begin
				ctl.clr = 1'b0;
				mul_a   = MW'(aby_q);
				mul_b   = MW'(aby_q);
			end
			OP_DT0: begin
				mul_a = MW'(apx_q);
				mul_b = MW'(abx_q);
			end
			OP_DT1: begin
				ctl.clr = 1'b0;
				mul_a   = MW'(apy_q);
				mul_b   = MW'(aby_q);
			end
			OP_AP0: begin
				mul_a = MW'(apx_q);
				mul_b = MW'(apx_q);
			end
			OP_AP1: begin
				ctl.clr = 1'b0;
				mul_a   = MW'(apy_q);
				mul_b   = MW'(apy_q);
			end
			OP_BP0: begin
				mul_a = MW'(bpx_q);
				mul_b = MW'(bpx_q);
			end
			OP_BP1: begin
				ctl.clr = 1'b0;
				mul_a   = MW'(bpy_q);
				mul_b   = MW'(bpy_q);
			end
			OP_CR0: begin
				mul_a = MW'(abx_q);
				mul_b = MW'(apy_q);
			end
			OP_CR1: begin
				ctl.clr = 1'b0;
				ctl.sub = 1'b1;
				mul_a   = MW'(aby_q);
				mul_b   = MW'(apx_q);
			end
			OP_SQ_HH: begin
				ctl.shift = SH_HIGH;
				mul_a     = MW'(c_q[CW-1:H]);
				mul_b     = MW'(c_q[CW-1:H]);
			end
			OP_SQ_HL: begin
				ctl.clr   = 1'b0;
				ctl.shift = SH_MID;
				mul_a     = MW'(c_q[CW-1:H]);
				mul_b     = MW'(c_q[H-1:0]);
			end
			OP_SQ_LL: begin
				ctl.clr = 1'b0;
				mul_a   = MW'(c_q[H-1:0]);
				mul_b   = MW'(c_q[H-1:0]);
			end
			default: begin
				ctl = '{clr: 1'b1, sub: 1'b0, shift: SH_NONE};
			end
		endcase
	end

	ppd_mul #(
		.W (MW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	always_comb begin
		prod_ext = ACC_W'(mul_p);
		unique case (ctl.shift)
			SH_NONE: term = prod_ext;
			SH_MID:  term = prod_ext <<< (H + 1);
			SH_HIGH: term = prod_ext <<< (2 * H);
			default: term = prod_ext;
		endcase
		base     = ctl.clr ? '0 : acc_q;
		acc_next = ctl.sub ? (base - term) : (base + term);
		acc_mag  = acc_next[ACC_W-1] ? -acc_next : acc_next;
	end

	assign sq_scaled = {acc_next[LEN_W-1:0], {(2*FRAC_BITS){1'b0}}};
	assign sq_wide   = WB'(sq_scaled);
	assign cand_end  = (|sq_wide[WB-1:BEST_W]) ? '1 : sq_wide[BEST_W-1:0];
	assign best_min  = (cand_q < best_q) ? cand_q : best_q;
	assign dt_le0    = dt_q[DT_W-1] || (dt_q == '0);
	assign dt_ge_len = dt_q[LEN_W-1:0] >= len_q;

	ppd_div #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_next[NUM_W-1:0]),
		.den    (len_q),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	ppd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (best_min),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && req.command == CMD_VERTEX && (have_q || req.is_last))
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				op_d    = OP_LEN0;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_MUL;
				unique case (op_q)
					OP_LEN0:  op_d = OP_LEN1;
					OP_LEN1:  op_d = OP_DT0;
					OP_DT0:   op_d = OP_DT1;
					OP_DT1:   state_d = ST_DECIDE;
					OP_AP0:   op_d = OP_AP1;
					OP_AP1:   state_d = ST_MIN;
					OP_BP0:   op_d = OP_BP1;
					OP_BP1:   state_d = ST_MIN;
					OP_CR0:   op_d = OP_CR1;
					OP_CR1:   op_d = OP_SQ_HH;
					OP_SQ_HH: op_d = OP_SQ_HL;
					OP_SQ_HL: op_d = OP_SQ_LL;
					OP_SQ_LL: begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_DECIDE: begin
				state_d = ST_MUL;
				priority if (len_q == '0 || dt_le0)
					op_d = OP_AP0;
				else if (dt_ge_len)
					op_d = OP_BP0;
				else
					op_d = OP_CR0;
			end
			ST_DIV: begin
				if (!div_busy)
					state_d = ST_MIN;
			end
			ST_MIN: begin
				priority if (close_q) begin
					state_d = ST_SETUP;
				end else if (emit_q) begin
					sqrt_start = 1'b1;
					state_d    = ST_SQRT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SQRT: begin
				if (!sqrt_busy && (!out_valid_q || rsp.ready)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_LEN0;
			query_x_q   <= '0;
			query_y_q   <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_q      <= 1'b0;
			close_q     <= 1'b0;
			emit_q      <= 1'b0;
			best_q      <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (in_fire) begin
				if (req.command == CMD_QUERY) begin
					query_x_q <= req.coord_x;
					query_y_q <= req.coord_y;
					have_q    <= 1'b0;
					best_q    <= '1;
				end else begin
					prev_x_q <= req.coord_x;
					prev_y_q <= req.coord_y;
					have_q   <= 1'b1;
					emit_q   <= req.is_last;
					close_q  <= have_q && req.is_last;
					if (!have_q) begin
						first_x_q <= req.coord_x;
						first_y_q <= req.coord_y;
					end
				end
			end
			if (state_q == ST_MIN) begin
				close_q <= 1'b0;
				if (sqrt_start) begin
					best_q <= '1;
					have_q <= 1'b0;
				end else begin
					best_q <= best_min;
				end
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && req.command == CMD_VERTEX) begin
			a_x_q <= have_q ? prev_x_q : req.coord_x;
			a_y_q <= have_q ? prev_y_q : req.coord_y;
			b_x_q <= req.coord_x;
			b_y_q <= req.coord_y;
		end
		if (state_q == ST_MIN && close_q) begin
			a_x_q <= b_x_q;
			a_y_q <= b_y_q;
			b_x_q <= first_x_q;
			b_y_q <= first_y_q;
		end
		if (state_q == ST_SETUP) begin
			abx_q <= DW'(b_x_q) - DW'(a_x_q);
			aby_q <= DW'(b_y_q) - DW'(a_y_q);
			apx_q <= DW'(query_x_q) - DW'(a_x_q);
			apy_q <= DW'(query_y_q) - DW'(a_y_q);
			bpx_q <= DW'(query_x_q) - DW'(b_x_q);
			bpy_q <= DW'(query_y_q) - DW'(b_y_q);
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_next;
			if (op_q == OP_LEN1)
				len_q <= acc_next[LEN_W-1:0];
			if (op_q == OP_DT1)
				dt_q <= acc_next[DT_W-1:0];
			if (op_q == OP_AP1 || op_q == OP_BP1)
				cand_q <= cand_end;
			if (op_q == OP_CR1)
				c_q <= acc_mag[CW-1:0];
		end
		if (state_q == ST_DIV && !div_busy)
			cand_q <= div_quot;
		if (out_load)
			dist_q <= sqrt_root;
	end

	`PPD_ASSERT_IMP(a_div_owned, clk, arst_n, div_busy, state_q == ST_DIV)
	`PPD_ASSERT_IMP(a_sqrt_owned, clk, arst_n, sqrt_busy, state_q == ST_SQRT)
	`PPD_ASSERT_NEXT(a_query_clears, clk, arst_n, in_fire && req.command == CMD_QUERY, best_q == '1 && !have_q)

endmodule
